// ===== rtl/core/tdcc_pkg.sv =====
// Package for the tick-driven calendar clock: types, constants and helper functions.
`default_nettype none

package tdcc_pkg;

  // Field widths.
  localparam int unsigned TickW  = 16;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned ByteW  = 8;

  // Stream payload widths.
  localparam int unsigned InDataW  = 6 * ByteW;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;

  // Reset and limit values.
  localparam logic [TickW-1:0] TpsReset    = 16'd1024;
  localparam logic [YearW-1:0] BaseYear    = 12'd2000;
  localparam logic [YearW-1:0] YearMax     = 12'd4095;
  localparam logic [SecW:0]    SecLimit    = 7'd60;
  localparam logic [MinW:0]    MinLimit    = 7'd60;
  localparam logic [HourW:0]   HourLimit   = 6'd24;
  localparam logic [MonW:0]    MonLast     = 5'd12;
  localparam logic [DayW-1:0]  FirstDay    = 5'd1;
  localparam logic [MonW-1:0]  FirstMonth  = 4'd1;

  // Divisibility by 25 through the multiplicative inverse of 25 modulo 2^12:
  // y is a multiple of 25 exactly when y * Inv25 (mod 4096) <= 4095 / 25.
  localparam logic [YearW-1:0] Inv25       = 12'd3113;
  localparam logic [YearW-1:0] Div25Bound  = 12'd163;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // Time and date held by the clock.
  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } cal_t;

  // Convert one BCD byte as high nibble times ten plus low nibble.
  function automatic logic [ByteW-1:0] bcd_to_bin(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] hi;
    logic [ByteW-1:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

  // Gregorian leap year: a multiple of 4, except centuries not divisible by 400.
  function automatic logic year_is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * Inv25;
    div25 = (prod <= Div25Bound);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
  endfunction

  // Days in a month; months outside 1 to 12 count as 31 days.
  function automatic logic [DayW-1:0] days_in_month(input logic [MonW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tick_driven_calendar_clock.sv =====
// Top level of the tick-driven calendar clock with Gregorian leap years.
//
//   Channel   Ports                          Direction  Carries
//   input     in_tvalid/tready/tdata/tuser   slave      tick or load transaction
//   result    out_tvalid/tready/tdata        master     time and date after it
//   config    cfg_we/cfg_wdata               write      ticks per second
//
// On each transaction, the prescaler, the full carry chain from
// second to year and the leap-year check settle between the state registers
// and the result register. A new transaction is taken every cycle while the
// result register is empty or being drained. Reset (synchronous, active low)
// sets 2000-01-01 00:00:00, a cleared prescaler and 1024 ticks per second.
// A stall on the result side holds the result and blocks new input.
`default_nettype none

module tick_driven_calendar_clock
  import tdcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Input stream.
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // tdata from bit 0: load_second, load_minute, load_hour, load_day,
  // load_month, load_year (8 bits each).
  input  wire logic [InDataW-1:0]   in_tdata,
  // tuser from bit 0: operation, values_are_bcd.
  input  wire logic [InUserW-1:0]   in_tuser,
  // Result stream.
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // tdata from bit 0: cur_second (6), cur_minute (6), cur_hour (5),
  // cur_day (5), cur_month (4), cur_year (12), second_elapsed (1), zero fill.
  output logic [OutDataW-1:0]       out_tdata,
  // Configuration.
  input  wire logic                 cfg_we,
  input  wire logic [TickW-1:0]     cfg_wdata
);

  logic [TickW-1:0] tps_r;
  logic [TickW-1:0] tick_count_r;
  logic [TickW-1:0] tick_count_nxt;
  cal_t             cal_r;
  cal_t             cal_nxt;
  logic             out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic [OutDataW-1:0] out_data_nxt;
  logic             elapsed;
  logic             accept;
  op_t              op;
  logic             is_bcd;

  // Load path signals.
  logic [ByteW-1:0] ld_byte [6];
  logic [ByteW-1:0] ld_val  [6];
  cal_t             cal_load;

  // Tick path signals.
  logic [TickW-1:0] tick_inc;
  logic [SecW:0]    sec_inc;
  logic [MinW:0]    min_inc;
  logic [HourW:0]   hour_inc;
  logic [DayW:0]    day_inc;
  logic [MonW:0]    mon_inc;
  logic [DayW-1:0]  month_len;
  logic             sec_wrap;
  logic             min_wrap;
  logic             hour_wrap;
  logic             day_wrap;
  logic             mon_wrap;
  cal_t             cal_tick;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign op        = op_t'(in_tuser[0]);
  assign is_bcd    = in_tuser[1];

  // Unpack and optionally convert the six load bytes.
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ld_byte[i] = in_tdata[i*ByteW +: ByteW];
      ld_val[i]  = is_bcd ? bcd_to_bin(ld_byte[i]) : ld_byte[i];
    end
    cal_load.second = ld_val[0][SecW-1:0];
    cal_load.minute = ld_val[1][MinW-1:0];
    cal_load.hour   = ld_val[2][HourW-1:0];
    cal_load.day    = ld_val[3][DayW-1:0];
    cal_load.month  = ld_val[4][MonW-1:0];
    cal_load.year   = {4'd0, ld_val[5]} + BaseYear;
  end

  // Prescaler and the carry chain from second to year.
  always_comb begin
    tick_inc  = tick_count_r + 16'd1;
    elapsed   = (tick_inc >= tps_r);
    sec_inc   = {1'b0, cal_r.second} + 7'd1;
    min_inc   = {1'b0, cal_r.minute} + 7'd1;
    hour_inc  = {1'b0, cal_r.hour} + 6'd1;
    day_inc   = {1'b0, cal_r.day} + 6'd1;
    mon_inc   = {1'b0, cal_r.month} + 5'd1;
    month_len = days_in_month(cal_r.month, year_is_leap(cal_r.year));
    sec_wrap  = (sec_inc >= SecLimit);
    min_wrap  = (min_inc >= MinLimit);
    hour_wrap = (hour_inc >= HourLimit);
    day_wrap  = (day_inc > {1'b0, month_len});
    mon_wrap  = (mon_inc > MonLast);

    cal_tick = cal_r;
    if (elapsed) begin
      cal_tick.second = sec_wrap ? '0 : sec_inc[SecW-1:0];
      if (sec_wrap) begin
        cal_tick.minute = min_wrap ? '0 : min_inc[MinW-1:0];
        if (min_wrap) begin
          cal_tick.hour = hour_wrap ? '0 : hour_inc[HourW-1:0];
          if (hour_wrap) begin
            cal_tick.day = day_wrap ? FirstDay : day_inc[DayW-1:0];
            if (day_wrap) begin
              cal_tick.month = mon_wrap ? FirstMonth : mon_inc[MonW-1:0];
              if (mon_wrap && (cal_r.year != YearMax)) begin
                cal_tick.year = cal_r.year + 12'd1;
              end
            end
          end
        end
      end
    end
  end

  // Select the next state and pack the result.
  always_comb begin
    tick_count_nxt = tick_count_r;
    cal_nxt        = cal_r;
    out_data_nxt   = '0;
    case (op)
      OP_LOAD: begin
        cal_nxt = cal_load;
      end
      OP_TICK: begin
        tick_count_nxt = elapsed ? '0 : tick_inc;
        cal_nxt        = cal_tick;
      end
      default: begin
        cal_nxt = cal_r;
      end
    endcase
    out_data_nxt[5:0]   = cal_nxt.second;
    out_data_nxt[11:6]  = cal_nxt.minute;
    out_data_nxt[16:12] = cal_nxt.hour;
    out_data_nxt[21:17] = cal_nxt.day;
    out_data_nxt[25:22] = cal_nxt.month;
    out_data_nxt[37:26] = cal_nxt.year;
    out_data_nxt[38]    = (op == OP_TICK) && elapsed;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TpsReset;
    end else if (cfg_we) begin
      tps_r <= cfg_wdata;
    end
  end

  // Clock state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r <= '0;
      cal_r.second <= '0;
      cal_r.minute <= '0;
      cal_r.hour   <= '0;
      cal_r.day    <= FirstDay;
      cal_r.month  <= FirstMonth;
      cal_r.year   <= BaseYear;
    end else if (accept) begin
      tick_count_r <= tick_count_nxt;
      cal_r        <= cal_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
